@@ sv/greedy_change_dispenser_defines.svh @@
// Assertion macros for the change dispenser.
`ifndef GREEDY_CHANGE_DISPENSER_DEFINES_SVH
`define GREEDY_CHANGE_DISPENSER_DEFINES_SVH

`ifndef SYNTHESIS
// Property that holds at every clock edge outside reset.
`define CHGDISP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("chgdisp: check failed");
// Condition at one edge implies a condition at the next edge.
`define CHGDISP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("chgdisp: check failed");
`else
`define CHGDISP_ASSERT(lbl, clk, rstn, prop)
`define CHGDISP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/chgdisp_pkg.sv @@
// Shared types and constants of the change dispenser.
package chgdisp_pkg;

  localparam int NUM_DENOMS  = 8;
  localparam int DUE_BITS    = 16;
  localparam int INS_BITS    = 8;
  localparam int GIVE_BITS   = 16;
  // inserted value tops out at 255 * 3641 cents, below 2^20
  localparam int AMT_BITS    = 20;
  localparam int CENTS_BITS  = 11;
  localparam int RECIP_BITS  = 32;

  localparam logic [GIVE_BITS-1:0] GIVE_MAX = {GIVE_BITS{1'b1}};

  // largest first
  localparam logic [CENTS_BITS-1:0] DENOM_CENTS [NUM_DENOMS] = '{
    11'd2000, 11'd1000, 11'd500, 11'd100, 11'd25, 11'd10, 11'd5, 11'd1
  };

  typedef enum logic [1:0] {
    OC_PAID      = 2'd0,
    OC_SHORT_PAY = 2'd1,
    OC_NO_STOCK  = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_ACC,
    TS_GRD,
    TS_FIN
  } top_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_FIX,
    CS_TAKE
  } cell_step_e;

  // token and running amount handed from one cell to the next
  typedef struct packed {
    logic                acc;
    logic                grd;
    logic [AMT_BITS-1:0] amt;
  } chain_t;

endpackage

@@ sv/chgdisp_cell.sv @@
// One denomination cell: stock count, inserted count and greedy take.
module chgdisp_cell #(
  parameter int                                  STOCK_BITS = 16,
  parameter logic [chgdisp_pkg::CENTS_BITS-1:0] DENOM      = 11'd1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [chgdisp_pkg::INS_BITS-1:0]    ins_i,
  input  logic                                commit_i,
  input  chgdisp_pkg::chain_t                 link_i,
  output chgdisp_pkg::chain_t                 link_o,
  output logic [chgdisp_pkg::INS_BITS-1:0]    ins_o,
  output logic [chgdisp_pkg::GIVE_BITS-1:0]   give_o
);

  localparam int AB = chgdisp_pkg::AMT_BITS;
  localparam int CB = chgdisp_pkg::CENTS_BITS;
  localparam int GB = chgdisp_pkg::GIVE_BITS;
  localparam int IB = chgdisp_pkg::INS_BITS;
  localparam int RB = chgdisp_pkg::RECIP_BITS;
  localparam int WIDE_BITS = (STOCK_BITS > GB) ? STOCK_BITS : GB;
  // floor((2^32-1)/DENOM): estimate is low by at most one
  localparam logic [RB-1:0] RECIP = RB'(64'hFFFF_FFFF / 64'(DENOM));

  logic [STOCK_BITS-1:0]   stock_q, stock_d;
  logic [IB-1:0]           ins_q;
  logic [GB-1:0]           give_q;
  logic [AB-1:0]           cur_q;
  logic [AB-1:0]           qest_q;
  logic [AB-1:0]           quo_q, quo_d;
  logic [CB-1:0]           rem_q, rem_d;
  chgdisp_pkg::cell_step_e step_q, step_d;
  chgdisp_pkg::chain_t     link_d;

  logic [STOCK_BITS:0]     stock_sum;
  logic [STOCK_BITS-1:0]   stock_sat;
  logic [WIDE_BITS-1:0]    sat_w;
  logic [GB-1:0]           lim;
  logic [AB+RB-1:0]        est_prod;
  logic [AB+CB-1:0]        fix_prod;
  logic [AB-1:0]           rem_full;
  logic                    limited;
  logic [GB-1:0]           take_cnt;
  logic [GB+CB-1:0]        take_prod;
  logic [AB-1:0]           left_amt;
  logic [IB+CB-1:0]        acc_prod;

  // stock with this payment's pieces added, saturating
  always_comb begin
    stock_sum = {1'b0, stock_q} + (STOCK_BITS + 1)'(ins_q);
    stock_sat = stock_sum[STOCK_BITS] ? {STOCK_BITS{1'b1}} : stock_sum[STOCK_BITS-1:0];
    sat_w     = WIDE_BITS'(stock_sat);
    lim       = (sat_w > WIDE_BITS'(chgdisp_pkg::GIVE_MAX)) ? chgdisp_pkg::GIVE_MAX
                                                            : GB'(sat_w);
  end

  always_comb begin
    step_d = chgdisp_pkg::CS_IDLE;
    case (step_q)
      chgdisp_pkg::CS_IDLE: begin
        if (link_i.grd) step_d = chgdisp_pkg::CS_FIX;
      end
      chgdisp_pkg::CS_FIX:  step_d = chgdisp_pkg::CS_TAKE;
      chgdisp_pkg::CS_TAKE: step_d = chgdisp_pkg::CS_IDLE;
      default:              step_d = chgdisp_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    est_prod = link_i.amt * RECIP;

    // correct the reciprocal estimate
    fix_prod = qest_q * DENOM;
    rem_full = cur_q - AB'(fix_prod);
    if (rem_full >= AB'(DENOM)) begin
      quo_d = qest_q + AB'(1);
      rem_d = CB'(rem_full - AB'(DENOM));
    end else begin
      quo_d = qest_q;
      rem_d = CB'(rem_full);
    end

    limited   = quo_q > AB'(lim);
    take_cnt  = limited ? lim : quo_q[GB-1:0];
    take_prod = take_cnt * DENOM;
    left_amt  = limited ? (cur_q - AB'(take_prod)) : AB'(rem_q);

    acc_prod  = ins_q * DENOM;

    link_d = '0;
    if (link_i.acc) begin
      link_d.acc = 1'b1;
      link_d.amt = link_i.amt + AB'(acc_prod);
    end else if (step_q == chgdisp_pkg::CS_TAKE) begin
      link_d.grd = 1'b1;
      link_d.amt = left_amt;
    end

    stock_d = stock_sat - STOCK_BITS'(give_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stock_q <= '0;
      step_q  <= chgdisp_pkg::CS_IDLE;
      link_o  <= '0;
    end else begin
      step_q <= step_d;
      link_o <= link_d;
      if (commit_i) stock_q <= stock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) ins_q <= ins_i;
    if (link_i.grd) begin
      cur_q  <= link_i.amt;
      qest_q <= est_prod[AB+RB-1:RB];
    end
    if (step_q == chgdisp_pkg::CS_FIX) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (step_q == chgdisp_pkg::CS_TAKE) give_q <= take_cnt;
  end

  assign ins_o  = ins_q;
  assign give_o = give_q;

endmodule

@@ sv/greedy_change_dispenser.sv @@
// Greedy change dispenser: a payment enters, a token walks the row of eight
// denomination cells once to total the inserted value and, if that covers the
// amount due, once more to take change greedily from the stock, largest piece
// first. The total takes one step in each cell and the change three in each
// (reciprocal estimate, correction, stock-limited take). A new payment is
// accepted only after the result of the last one has gone to the output
// register. Payments short of the amount due finish after the first walk.
// Stock changes only when change is paid in full; a refund leaves it as it
// was. Stock counts saturate at 2^STOCK_BITS-1 and reset to zero.
`include "greedy_change_dispenser_defines.svh"

module greedy_change_dispenser #(
  parameter int STOCK_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] due_cents_i,
  input  logic [7:0]  in_twenties_i,
  input  logic [7:0]  in_tens_i,
  input  logic [7:0]  in_fives_i,
  input  logic [7:0]  in_ones_i,
  input  logic [7:0]  in_quarters_i,
  input  logic [7:0]  in_dimes_i,
  input  logic [7:0]  in_nickels_i,
  input  logic [7:0]  in_pennies_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [15:0] out_twenties_o,
  output logic [15:0] out_tens_o,
  output logic [15:0] out_fives_o,
  output logic [15:0] out_ones_o,
  output logic [15:0] out_quarters_o,
  output logic [15:0] out_dimes_o,
  output logic [15:0] out_nickels_o,
  output logic [15:0] out_pennies_o
);

  localparam int ND = chgdisp_pkg::NUM_DENOMS;
  localparam int AB = chgdisp_pkg::AMT_BITS;
  localparam int GB = chgdisp_pkg::GIVE_BITS;
  localparam int IB = chgdisp_pkg::INS_BITS;

  chgdisp_pkg::top_state_e state_q, state_d;
  chgdisp_pkg::outcome_e   code_q, code_d;
  chgdisp_pkg::outcome_e   outcome_q;
  chgdisp_pkg::chain_t     head_q, head_d;
  logic [chgdisp_pkg::DUE_BITS-1:0] due_q;
  logic                    out_valid_q;
  logic [GB-1:0]           out_cnt_q [ND];

  chgdisp_pkg::chain_t     link_w [ND+1];
  logic [IB-1:0]           ins_w  [ND];
  logic [GB-1:0]           give_w [ND];
  logic [IB-1:0]           in_cnt [ND];
  logic [ND:0]             tok_vec;
  chgdisp_pkg::chain_t     tail;

  logic in_xfer;
  logic load;
  logic commit;
  logic out_load;

  assign in_cnt[0] = in_twenties_i;
  assign in_cnt[1] = in_tens_i;
  assign in_cnt[2] = in_fives_i;
  assign in_cnt[3] = in_ones_i;
  assign in_cnt[4] = in_quarters_i;
  assign in_cnt[5] = in_dimes_i;
  assign in_cnt[6] = in_nickels_i;
  assign in_cnt[7] = in_pennies_i;

  assign link_w[0] = head_q;
  assign tail      = link_w[ND];

  for (genvar i = 0; i < ND; i++) begin : g_cell
    chgdisp_cell #(
      .STOCK_BITS (STOCK_BITS),
      .DENOM      (chgdisp_pkg::DENOM_CENTS[i])
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (load),
      .ins_i    (in_cnt[i]),
      .commit_i (commit),
      .link_i   (link_w[i]),
      .link_o   (link_w[i+1]),
      .ins_o    (ins_w[i]),
      .give_o   (give_w[i])
    );
  end

  for (genvar i = 0; i <= ND; i++) begin : g_tok
    assign tok_vec[i] = link_w[i].acc | link_w[i].grd;
  end

  assign in_stall_o = (state_q != chgdisp_pkg::TS_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      chgdisp_pkg::TS_IDLE: begin
        if (in_xfer) state_d = chgdisp_pkg::TS_ACC;
      end
      chgdisp_pkg::TS_ACC: begin
        if (tail.acc) begin
          state_d = (tail.amt < AB'(due_q)) ? chgdisp_pkg::TS_FIN : chgdisp_pkg::TS_GRD;
        end
      end
      chgdisp_pkg::TS_GRD: begin
        if (tail.grd) state_d = chgdisp_pkg::TS_FIN;
      end
      chgdisp_pkg::TS_FIN: begin
        if (!out_valid_q || !out_stall_i) state_d = chgdisp_pkg::TS_IDLE;
      end
      default: state_d = chgdisp_pkg::TS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load     = 1'b0;
    commit   = 1'b0;
    out_load = 1'b0;
    head_d   = '0;
    code_d   = code_q;
    case (state_q)
      chgdisp_pkg::TS_IDLE: begin
        if (in_xfer) begin
          load       = 1'b1;
          head_d.acc = 1'b1;
        end
      end
      chgdisp_pkg::TS_ACC: begin
        if (tail.acc) begin
          if (tail.amt < AB'(due_q)) begin
            code_d = chgdisp_pkg::OC_SHORT_PAY;
          end else begin
            head_d.grd = 1'b1;
            head_d.amt = tail.amt - AB'(due_q);
          end
        end
      end
      chgdisp_pkg::TS_GRD: begin
        if (tail.grd) begin
          code_d = (tail.amt == '0) ? chgdisp_pkg::OC_PAID : chgdisp_pkg::OC_NO_STOCK;
        end
      end
      chgdisp_pkg::TS_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          commit   = (code_q == chgdisp_pkg::OC_PAID);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chgdisp_pkg::TS_IDLE;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    if (in_xfer) due_q <= due_cents_i;
    if (out_load) begin
      outcome_q <= code_q;
      for (int i = 0; i < ND; i++) begin
        out_cnt_q[i] <= (code_q == chgdisp_pkg::OC_PAID) ? give_w[i] : GB'(ins_w[i]);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = outcome_q;
  assign out_twenties_o = out_cnt_q[0];
  assign out_tens_o     = out_cnt_q[1];
  assign out_fives_o    = out_cnt_q[2];
  assign out_ones_o     = out_cnt_q[3];
  assign out_quarters_o = out_cnt_q[4];
  assign out_dimes_o    = out_cnt_q[5];
  assign out_nickels_o  = out_cnt_q[6];
  assign out_pennies_o  = out_cnt_q[7];

  // only one payment walks the row at a time
  `CHGDISP_ASSERT(a_one_token, clk_i, rst_ni, $onehot0(tok_vec))
  `CHGDISP_ASSERT(a_idle_empty, clk_i, rst_ni, (state_q == chgdisp_pkg::TS_IDLE) |-> (tok_vec == '0))
  `CHGDISP_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, in_stall_o)
  `CHGDISP_ASSERT(a_acc_tail_state, clk_i, rst_ni, tail.acc |-> (state_q == chgdisp_pkg::TS_ACC))
  `CHGDISP_ASSERT(a_grd_tail_state, clk_i, rst_ni, tail.grd |-> (state_q == chgdisp_pkg::TS_GRD))

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the greedy change dispenser: payments in, change or refund out.
`timescale 1ns / 100ps

module testbench;

  localparam int STOCK_BITS = 16;
  localparam logic [31:0] STOCK_MAX = (32'd1 << STOCK_BITS) - 32'd1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [chgdisp_pkg::DUE_BITS-1:0]                                     due;
    logic [0:chgdisp_pkg::NUM_DENOMS-1][chgdisp_pkg::INS_BITS-1:0]        ins;
  } payment_t;

  typedef struct packed {
    chgdisp_pkg::outcome_e                                                outcome;
    logic [0:chgdisp_pkg::NUM_DENOMS-1][chgdisp_pkg::GIVE_BITS-1:0]       pieces;
  } handback_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [15:0] due_cents = '0;
  logic [7:0]  in_twenties = '0;
  logic [7:0]  in_tens = '0;
  logic [7:0]  in_fives = '0;
  logic [7:0]  in_ones = '0;
  logic [7:0]  in_quarters = '0;
  logic [7:0]  in_dimes = '0;
  logic [7:0]  in_nickels = '0;
  logic [7:0]  in_pennies = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b1;
  logic [1:0]  outcome_o;
  logic [15:0] out_twenties_o, out_tens_o, out_fives_o, out_ones_o;
  logic [15:0] out_quarters_o, out_dimes_o, out_nickels_o, out_pennies_o;

  logic [STOCK_BITS-1:0] model_stock [chgdisp_pkg::NUM_DENOMS];
  handback_t   handback_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_cycle = 0;
  logic [15:0] stall_mask = 16'hffff;
  int          burst_left = 0;
  int          gap_max = 0;
  string       denom_name [chgdisp_pkg::NUM_DENOMS] = '{"twenties", "tens", "fives", "ones",
                                                      "quarters", "dimes", "nickels",
                                                      "pennies"};

  greedy_change_dispenser #(.STOCK_BITS(STOCK_BITS)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .due_cents_i    (due_cents),
    .in_twenties_i  (in_twenties),
    .in_tens_i      (in_tens),
    .in_fives_i     (in_fives),
    .in_ones_i      (in_ones),
    .in_quarters_i  (in_quarters),
    .in_dimes_i     (in_dimes),
    .in_nickels_i   (in_nickels),
    .in_pennies_i   (in_pennies),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .outcome_o      (outcome_o),
    .out_twenties_o (out_twenties_o),
    .out_tens_o     (out_tens_o),
    .out_fives_o    (out_fives_o),
    .out_ones_o     (out_ones_o),
    .out_quarters_o (out_quarters_o),
    .out_dimes_o    (out_dimes_o),
    .out_nickels_o  (out_nickels_o),
    .out_pennies_o  (out_pennies_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver stall: a repeating 16-bit mask that is reshuffled at random
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) begin
      case ($urandom_range(3))
        0: stall_mask = 16'h0000;
        1: stall_mask = 16'($urandom);
        2: stall_mask = 16'($urandom & $urandom);
        default: stall_mask = 16'($urandom | $urandom);
      endcase
    end
    out_stall <= stall_mask[rx_cycle % 16];
  end

  function automatic logic [31:0] payment_value(payment_t p);
    logic [31:0] sum;
    sum = '0;
    for (int i = 0; i < chgdisp_pkg::NUM_DENOMS; i++) begin
      sum += 32'(p.ins[i]) * 32'(chgdisp_pkg::DENOM_CENTS[i]);
    end
    return sum;
  endfunction

  // Updates the model stock and returns the pieces the customer gets back.
  function automatic handback_t settle_payment(payment_t p);
    logic [STOCK_BITS-1:0] saved [chgdisp_pkg::NUM_DENOMS];
    logic [0:chgdisp_pkg::NUM_DENOMS-1][chgdisp_pkg::GIVE_BITS-1:0] give;
    logic [31:0] paid, rest, take, sum;
    handback_t hb;
    paid = payment_value(p);
    for (int i = 0; i < chgdisp_pkg::NUM_DENOMS; i++) begin
      saved[i] = model_stock[i];
      sum = 32'(model_stock[i]) + 32'(p.ins[i]);
      model_stock[i] = (sum > STOCK_MAX) ? STOCK_MAX[STOCK_BITS-1:0] : sum[STOCK_BITS-1:0];
      hb.pieces[i] = chgdisp_pkg::GIVE_BITS'(p.ins[i]);
    end
    if (paid < 32'(p.due)) begin
      model_stock = saved;
      hb.outcome = chgdisp_pkg::OC_SHORT_PAY;
      return hb;
    end
    rest = paid - 32'(p.due);
    for (int i = 0; i < chgdisp_pkg::NUM_DENOMS; i++) begin
      take = rest / 32'(chgdisp_pkg::DENOM_CENTS[i]);
      if (take > 32'(model_stock[i])) take = 32'(model_stock[i]);
      if (take > 32'(chgdisp_pkg::GIVE_MAX)) take = 32'(chgdisp_pkg::GIVE_MAX);
      give[i] = take[chgdisp_pkg::GIVE_BITS-1:0];
      rest -= take * 32'(chgdisp_pkg::DENOM_CENTS[i]);
    end
    if (rest != 0) begin
      model_stock = saved;
      hb.outcome = chgdisp_pkg::OC_NO_STOCK;
      return hb;
    end
    for (int i = 0; i < chgdisp_pkg::NUM_DENOMS; i++) begin
      model_stock[i] -= STOCK_BITS'(give[i]);
    end
    hb.pieces = give;
    hb.outcome = chgdisp_pkg::OC_PAID;
    return hb;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Call at a rising edge; returns at the edge of the transfer or after the gap.
  // counts: twenties in the top byte down to pennies in the bottom byte.
  task automatic send_payment(input logic [15:0] due, input logic [63:0] counts);
    payment_t p;
    p.due = due;
    p.ins = counts;
    in_valid    <= 1'b1;
    due_cents   <= p.due;
    in_twenties <= p.ins[0];
    in_tens     <= p.ins[1];
    in_fives    <= p.ins[2];
    in_ones     <= p.ins[3];
    in_quarters <= p.ins[4];
    in_dimes    <= p.ins[5];
    in_nickels  <= p.ins[6];
    in_pennies  <= p.ins[7];
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    handback_q = {handback_q, settle_payment(p)};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(15);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    handback_t want;
    logic [0:chgdisp_pkg::NUM_DENOMS-1][chgdisp_pkg::GIVE_BITS-1:0] got;
    if (rst_n && out_valid_o && !out_stall) begin
      got = {out_twenties_o, out_tens_o, out_fives_o, out_ones_o,
             out_quarters_o, out_dimes_o, out_nickels_o, out_pennies_o};
      if (handback_q.size() == 0) begin
        flag_error($sformatf("result with no payment pending: outcome %0d", outcome_o));
      end else begin
        want = handback_q.pop_front();
        if (outcome_o !== want.outcome)
          flag_error($sformatf("outcome: expected %0d, got %0d", want.outcome, outcome_o));
        for (int i = 0; i < chgdisp_pkg::NUM_DENOMS; i++) begin
          if (got[i] !== want.pieces[i])
            flag_error($sformatf("%s: expected %0d, got %0d", denom_name[i],
                                 want.pieces[i], got[i]));
        end
      end
    end
  end

  function automatic payment_t random_payment();
    payment_t p;
    int unsigned style, value, change;
    logic [31:0] due;
    style = $urandom_range(99);
    for (int i = 0; i < chgdisp_pkg::NUM_DENOMS; i++) begin
      if (style < 15) p.ins[i] = 8'($urandom_range(255));
      else if ($urandom_range(2) == 0) p.ins[i] = 8'($urandom_range(1, 4));
      else p.ins[i] = '0;
    end
    value = payment_value(p);
    style = $urandom_range(99);
    change = $urandom_range(2500);
    if (value > 65535 || style < 10) due = $urandom_range(65535);
    else if (style < 25) due = value;
    else if (style < 35) due = value + $urandom_range(1, 500);
    else due = (value > change) ? value - change : 0;
    if (due > 65535) due = 65535;
    p.due = due[15:0];
    return p;
  endfunction

  task automatic test_exact_and_zero_due();
    send_payment(16'd0,    64'h0000_0000_0000_0000);
    send_payment(16'd2000, 64'h0100_0000_0000_0000);
    send_payment(16'd0,    64'h0000_0000_0000_0001);
  endtask

  task automatic test_underpayment();
    send_payment(16'd1,     64'h0000_0000_0000_0000);
    send_payment(16'd65535, 64'h0000_0000_0000_0000);
    send_payment(16'd65535, 64'h0000_0000_ffff_ffff);
    send_payment(16'd101,   64'h0000_0001_0000_0000);
  endtask

  task automatic test_stock_shortage();
    send_payment(16'd1,    64'h0000_0001_0000_0000);
    send_payment(16'd1999, 64'h0100_0000_0000_0000);
    send_payment(16'd41,   64'h0000_0000_0101_0101);
    send_payment(16'd60,   64'h0000_0001_0000_0000);
    send_payment(16'd1,    64'h0000_0001_0000_0000);
  endtask

  // stock up, then make change from tens, fives, ones, quarters, dimes and pennies
  task automatic test_greedy_order();
    send_payment(16'd3500, 64'h0002_0205_0000_0000);
    send_payment(16'd1500, 64'h0100_0000_0000_0000);
    send_payment(16'd400,  64'h0000_0000_1000_0000);
    send_payment(16'd200,  64'h0000_0000_0014_0000);
    send_payment(16'd100,  64'h0000_0000_0000_1400);
    send_payment(16'd100,  64'h0000_0000_0000_0064);
    send_payment(16'd1,    64'h0100_0000_0000_0000);
  endtask

  task automatic test_field_extremes();
    send_payment(16'hffff, 64'hffff_ffff_ffff_ffff);
    send_payment(16'haaaa, 64'haa55_aa55_aa55_aa55);
    send_payment(16'h5555, 64'h55aa_55aa_55aa_55aa);
    send_payment(16'h0000, 64'hffff_ffff_ffff_ffff);
  endtask

  // fill the penny count past its top, then refund and pay out of it
  task automatic test_stock_saturation();
    repeat (258) send_payment(16'd255, 64'h0000_0000_0000_00ff);
    send_payment(16'd65535, 64'h0000_0000_0000_00ff);
    send_payment(16'd0,     64'h0000_0000_0000_00ff);
  endtask

  task automatic test_random_payments();
    payment_t p;
    for (int chunk = 0; chunk < 10; chunk++) begin
      gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 12);
      repeat (155) begin
        p = random_payment();
        send_payment(p.due, p.ins);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < chgdisp_pkg::NUM_DENOMS; i++) model_stock[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_max = 4;
    test_exact_and_zero_due();
    test_underpayment();
    test_stock_shortage();
    test_greedy_order();
    test_field_extremes();
    gap_max = 0;
    test_stock_saturation();
    test_random_payments();
    in_valid <= 1'b0;
    while (handback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
